[sv/iva_pkg.sv]
// Shared types and codes for the four-lane integer vector ALU.
// Depends on nothing; only the top level uses it.
`default_nettype none
package iva_pkg;

    // Operation codes of an input item
    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_NEGATE  = 4'd2,
        OP_SCALE   = 4'd3,
        OP_DIVIDE  = 4'd4,
        OP_DOT     = 4'd5,
        OP_EQUAL   = 4'd6,
        OP_IS_ZERO = 4'd7,
        OP_INVALID = 4'd8
    } op_t;

    localparam int FIELD_W = 32;

    // Partial result that travels beside the divider
    typedef struct packed {
        logic              is_div;
        logic [FIELD_W-1:0] r_x;
        logic [FIELD_W-1:0] r_y;
        logic [FIELD_W-1:0] r_z;
        logic [FIELD_W-1:0] r_w;
        logic [FIELD_W-1:0] dot_value;
        logic              test_flag;
        logic              result_invalid;
    } res_t;

endpackage
`default_nettype wire

[sv/iva_if.sv]
// Valid/ready channel interfaces: input items, result items, marker writes.
// Depends on nothing.
`default_nettype none
interface iva_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] a_w;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] b_w;
    logic [31:0] scalar;
    modport source (output valid, operation, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar,
                    input ready);
    modport sink (input valid, operation, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar,
                  output ready);
endinterface

interface iva_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [31:0] r_w;
    logic [31:0] dot_value;
    logic        test_flag;
    logic        result_invalid;
    modport source (output valid, r_x, r_y, r_z, r_w, dot_value, test_flag, result_invalid,
                    input ready);
    modport sink (input valid, r_x, r_y, r_z, r_w, dot_value, test_flag, result_invalid,
                  output ready);
endinterface

interface iva_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[sv/iva_div.sv]
// Pipelined restoring divider for one lane: one quotient bit per stage.
// Depends on nothing; instantiated once per lane by the top level.
`default_nettype none
module iva_div #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    input  wire logic         neg,
    output logic [W-1:0]      quo
);

    logic [W-1:0] rem_reg [W];
    logic [W-1:0] num_reg [W];
    logic [W-1:0] quo_reg [W];
    logic [W-1:0] den_reg [W];
    logic         neg_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0] rem_prev;
        logic [W-1:0] num_prev;
        logic [W-1:0] quo_prev;
        logic [W-1:0] den_prev;
        logic         neg_prev;
        logic [W:0]   shifted;
        logic         ge;
        logic [W:0]   diff;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign num_prev = num;
            assign quo_prev = '0;
            assign den_prev = den;
            assign neg_prev = neg;
        end else begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign num_prev = num_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign neg_prev = neg_reg[k-1];
        end

        // Trial subtract of the divisor from the shifted remainder
        assign shifted = {rem_prev, num_prev[W-1]};
        assign ge      = (shifted >= {1'b0, den_prev});
        assign diff    = shifted - {1'b0, den_prev};

        // Advance one quotient bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[W-1:0] : shifted[W-1:0];
                num_reg[k] <= {num_prev[W-2:0], 1'b0};
                quo_reg[k] <= {quo_prev[W-2:0], ge};
                den_reg[k] <= den_prev;
                neg_reg[k] <= neg_prev;
            end
        end
    end

    // Apply the sign; the most negative value over minus one wraps to itself
    assign quo = neg_reg[W-1] ? (~quo_reg[W-1] + W'(1)) : quo_reg[W-1];

endmodule
`default_nettype wire

[sv/int_vector4_alu_with_invalid_marker_top.sv]
// Four-lane signed integer vector ALU with an invalid-lane marker.
// Depends on iva_pkg, the interfaces in iva_if and the divider iva_div.
//
// Usage:
//   req carries one item: an operation, vectors a and b and a scalar.
//   rsp returns exactly one result item for each item accepted, in order.
//   cfg writes the invalid marker; it is always ready and must be written
//   only while no item is in flight.
// Pipeline: from acceptance on req to valid on rsp an item passes the
//   input register, one operand stage, LANE_WIDTH divider stages that
//   every item passes, and the output register. The length is set by the
//   one-bit-per-stage lane dividers.
// Throughput: one item per cycle unless rsp stalls; all stages advance together.
// Stall: while rsp is valid and not ready the whole pipeline holds and
//   req.ready is low; nothing is lost or repeated. Bubbles move through
//   freely, so ready stays high whenever the output register is free.
// Reset: rst_n clears every valid bit and sets the marker to the most
//   negative 32-bit value.
`default_nettype none
module int_vector4_alu_with_invalid_marker_top #(
    parameter int LANE_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    iva_in_if.sink    req,
    iva_out_if.source rsp,
    iva_cfg_if.sink   cfg
);

    localparam int W = LANE_WIDTH;
    localparam int DLY = W;

    // Field to lane: keep low bits, sign-extend when lanes are wider
    function automatic logic [W-1:0] to_lane(input logic [31:0] x);
        logic [W+31:0] t;
        t = {{W{x[31]}}, x};
        return t[W-1:0];
    endfunction

    function automatic logic [31:0] to_field(input logic [W-1:0] x);
        logic [W+31:0] t;
        t = {{32{x[W-1]}}, x};
        return t[31:0];
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + W'(1)) : x;
    endfunction

    logic en;
    logic [31:0] marker_reg;
    logic [W-1:0] marker;

    assign en = !rsp.valid || rsp.ready;
    assign req.ready = en;
    assign cfg.ready = 1'b1;
    assign marker = to_lane(marker_reg);

    // Hold the marker register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= 32'h8000_0000;
        else if (cfg.valid)
            marker_reg <= cfg.data;
    end

    // Stage A: capture the item
    logic         va_reg;
    iva_pkg::op_t op_a_reg;
    logic [W-1:0] a_a_reg [4];
    logic [W-1:0] b_a_reg [4];
    logic [W-1:0] s_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg   <= iva_pkg::op_t'(req.operation);
            a_a_reg[0] <= to_lane(req.a_x);
            a_a_reg[1] <= to_lane(req.a_y);
            a_a_reg[2] <= to_lane(req.a_z);
            a_a_reg[3] <= to_lane(req.a_w);
            b_a_reg[0] <= to_lane(req.b_x);
            b_a_reg[1] <= to_lane(req.b_y);
            b_a_reg[2] <= to_lane(req.b_z);
            b_a_reg[3] <= to_lane(req.b_w);
            s_a_reg    <= to_lane(req.scalar);
        end
    end

    // Stage B: lane arithmetic, products, tests and divider operands
    logic inv_a, inv_b, eq_all, zero_all, s_zero;
    logic [W-1:0] lane_next [4];
    logic [W-1:0] prod_next [4];

    always_comb
    begin
        inv_a = 1'b0;
        inv_b = 1'b0;
        eq_all = 1'b1;
        zero_all = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (a_a_reg[i] == marker) inv_a = 1'b1;
            if (b_a_reg[i] == marker) inv_b = 1'b1;
            if (a_a_reg[i] != b_a_reg[i]) eq_all = 1'b0;
            if (a_a_reg[i] != '0) zero_all = 1'b0;
            prod_next[i] = W'(a_a_reg[i] *
                              ((op_a_reg == iva_pkg::OP_SCALE) ? s_a_reg : b_a_reg[i]));
            case (op_a_reg)
                iva_pkg::OP_ADD:    lane_next[i] = a_a_reg[i] + b_a_reg[i];
                iva_pkg::OP_SUB:    lane_next[i] = a_a_reg[i] - b_a_reg[i];
                iva_pkg::OP_NEGATE: lane_next[i] = ~a_a_reg[i] + W'(1);
                default:            lane_next[i] = '0;
            endcase
        end
        s_zero = (s_a_reg == '0);
    end

    logic         vb_reg;
    iva_pkg::op_t op_b_reg;
    logic [W-1:0] lane_b_reg [4];
    logic [W-1:0] prod_b_reg [4];
    logic [W-1:0] num_b_reg [4];
    logic         neg_b_reg [4];
    logic [W-1:0] den_b_reg;
    logic         inv_a_b_reg, inv_b_b_reg, eq_b_reg, zero_b_reg, s_zero_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_b_reg     <= op_a_reg;
            inv_a_b_reg  <= inv_a;
            inv_b_b_reg  <= inv_b;
            eq_b_reg     <= eq_all;
            zero_b_reg   <= zero_all;
            s_zero_b_reg <= s_zero;
            den_b_reg    <= mag(s_a_reg);
            for (int i = 0; i < 4; i++)
            begin
                lane_b_reg[i] <= lane_next[i];
                prod_b_reg[i] <= prod_next[i];
                num_b_reg[i]  <= mag(a_a_reg[i]);
                neg_b_reg[i]  <= a_a_reg[i][W-1] ^ s_a_reg[W-1];
            end
        end
    end

    // Lane dividers start from stage B
    logic [W-1:0] quo [4];

    for (genvar g = 0; g < 4; g++) begin : g_div
        iva_div #(.W(W)) u_div (
            .clk (clk),
            .en  (en),
            .num (num_b_reg[g]),
            .den (den_b_reg),
            .neg (neg_b_reg[g]),
            .quo (quo[g])
        );
    end

    // Stage C: dot sum, marker substitution, test answers
    iva_pkg::res_t res_c_next;
    logic [W-1:0]  vec_c [4];
    logic [W-1:0]  dot_sum;
    logic          bad;

    always_comb
    begin
        dot_sum = prod_b_reg[0] + prod_b_reg[1] + prod_b_reg[2] + prod_b_reg[3];
        bad = 1'b0;
        res_c_next = '0;
        for (int i = 0; i < 4; i++)
            vec_c[i] = '0;
        case (op_b_reg)
            iva_pkg::OP_ADD, iva_pkg::OP_SUB:
            begin
                bad = inv_a_b_reg || inv_b_b_reg;
                for (int i = 0; i < 4; i++)
                    vec_c[i] = bad ? marker : lane_b_reg[i];
            end
            iva_pkg::OP_NEGATE:
            begin
                bad = inv_a_b_reg;
                for (int i = 0; i < 4; i++)
                    vec_c[i] = bad ? marker : lane_b_reg[i];
            end
            iva_pkg::OP_SCALE:
            begin
                bad = inv_a_b_reg;
                for (int i = 0; i < 4; i++)
                    vec_c[i] = bad ? marker : prod_b_reg[i];
            end
            iva_pkg::OP_DIVIDE:
            begin
                bad = inv_a_b_reg || s_zero_b_reg;
                res_c_next.is_div = !bad;
                for (int i = 0; i < 4; i++)
                    vec_c[i] = marker;
            end
            iva_pkg::OP_DOT:
            begin
                bad = inv_a_b_reg || inv_b_b_reg;
                res_c_next.dot_value = to_field(bad ? marker : dot_sum);
            end
            iva_pkg::OP_EQUAL:
                res_c_next.test_flag = !inv_a_b_reg && !inv_b_b_reg && eq_b_reg;
            iva_pkg::OP_IS_ZERO:
                res_c_next.test_flag = zero_b_reg;
            iva_pkg::OP_INVALID:
                res_c_next.test_flag = inv_a_b_reg;
            default: ;
        endcase
        res_c_next.result_invalid = bad;
        res_c_next.r_x = to_field(vec_c[0]);
        res_c_next.r_y = to_field(vec_c[1]);
        res_c_next.r_z = to_field(vec_c[2]);
        res_c_next.r_w = to_field(vec_c[3]);
    end

    // Delay line: hold stage C results until the quotients arrive
    iva_pkg::res_t dly_reg [DLY];
    logic          dly_v_reg [DLY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLY; i++)
                dly_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            dly_v_reg[0] <= vb_reg;
            for (int i = 1; i < DLY; i++)
                dly_v_reg[i] <= dly_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= res_c_next;
            for (int i = 1; i < DLY; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    // Output register: merge quotients for a valid divide
    iva_pkg::res_t res_out_next;
    iva_pkg::res_t res_out_reg;
    logic          out_v_reg;

    always_comb
    begin
        res_out_next = dly_reg[DLY-1];
        if (dly_reg[DLY-1].is_div)
        begin
            res_out_next.r_x = to_field(quo[0]);
            res_out_next.r_y = to_field(quo[1]);
            res_out_next.r_z = to_field(quo[2]);
            res_out_next.r_w = to_field(quo[3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dly_v_reg[DLY-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_out_reg <= res_out_next;
    end

    assign rsp.valid          = out_v_reg;
    assign rsp.r_x            = res_out_reg.r_x;
    assign rsp.r_y            = res_out_reg.r_y;
    assign rsp.r_z            = res_out_reg.r_z;
    assign rsp.r_w            = res_out_reg.r_w;
    assign rsp.dot_value      = res_out_reg.dot_value;
    assign rsp.test_flag      = res_out_reg.test_flag;
    assign rsp.result_invalid = res_out_reg.result_invalid;

    // A test answer never comes with a forced marker
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.test_flag && rsp.result_invalid))
        else $error("test flag and invalid flag both set");

    // A test answer carries no vector and no dot product
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.test_flag |-> rsp.r_x == '0 && rsp.r_w == '0 && rsp.dot_value == '0)
        else $error("test result carries arithmetic fields");

    // A stalled result item stays valid and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.r_x) && $stable(rsp.dot_value))
        else $error("output lost while stalled");

endmodule
`default_nettype wire
